// File: rtl/tws_pkg.sv
`default_nettype none

package tws_pkg;

    // action codes as carried on the request channel
    localparam logic [2:0] ACT_SCHEDULE   = 3'd0;
    localparam logic [2:0] ACT_UNSCHEDULE = 3'd1;
    localparam logic [2:0] ACT_READ       = 3'd2;
    localparam logic [2:0] ACT_STEP_FWD   = 3'd3;
    localparam logic [2:0] ACT_STEP_BACK  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK            = 2'd0;
    localparam logic [1:0] ST_OVERFLOW      = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW     = 2'd2;
    localparam logic [1:0] ST_BACK_NONEMPTY = 2'd3;

    // command queue between front and back
    localparam int CMD_Q_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_SCHED,
        OP_UNSCHED,
        OP_READ,
        OP_FWD,
        OP_BACK,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [3:0]         delay;
        logic [15:0]        socket_id;
        logic signed [31:0] event_value;
    } t_cmd;

    typedef struct packed {
        logic               has_event;
        logic [15:0]        out_socket;
        logic signed [31:0] out_value;
        logic               last;
        logic [6:0]         slot_count;
        logic [10:0]        pending_total;
        logic [3:0]         now_slot;
        logic [1:0]         status;
    } t_rsp;

endpackage

`default_nettype wire

// File: rtl/tws_ifs.sv
`default_nettype none

interface tws_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [3:0]         delay;
    logic [15:0]        socket_id;
    logic signed [31:0] event_value;

    modport source (output valid, output action, output delay, output socket_id,
                    output event_value, input ready);
    modport sink   (input valid, input action, input delay, input socket_id,
                    input event_value, output ready);
endinterface

interface tws_rsp_if;
    logic               valid;
    logic               ready;
    logic               has_event;
    logic [15:0]        out_socket;
    logic signed [31:0] out_value;
    logic               last;
    logic [6:0]         slot_count;
    logic [10:0]        pending_total;
    logic [3:0]         now_slot;
    logic [1:0]         status;

    modport source (output valid, output has_event, output out_socket, output out_value,
                    output last, output slot_count, output pending_total,
                    output now_slot, output status, input ready);
    modport sink   (input valid, input has_event, input out_socket, input out_value,
                    input last, input slot_count, input pending_total,
                    input now_slot, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/tws_front.sv
`default_nettype none

module tws_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    tws_req_if.sink          i_req,
    output logic             o_cmd_vld,
    output tws_pkg::t_cmd    o_cmd,
    input  wire              i_cmd_rdy
);
    import tws_pkg::*;

    logic r_vld;
    t_cmd r_cmd;
    t_op  dec_op;

    always_comb begin
        unique case (i_req.action)
            ACT_SCHEDULE:   dec_op = OP_SCHED;
            ACT_UNSCHEDULE: dec_op = OP_UNSCHED;
            ACT_READ:       dec_op = OP_READ;
            ACT_STEP_FWD:   dec_op = OP_FWD;
            ACT_STEP_BACK:  dec_op = OP_BACK;
            default:        dec_op = OP_NOP;
        endcase
    end

    assign i_req.ready = !r_vld || i_cmd_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_vld               <= 1'b1;
                r_cmd.op            <= dec_op;
                r_cmd.delay         <= i_req.delay;
                r_cmd.socket_id     <= i_req.socket_id;
                r_cmd.event_value   <= i_req.event_value;
            end else if (i_cmd_rdy) begin
                r_vld <= 1'b0;
            end
        end
    end

    assign o_cmd_vld = r_vld;
    assign o_cmd     = r_cmd;

endmodule

`default_nettype wire

// File: rtl/tws_cmd_fifo.sv
`default_nettype none

module tws_cmd_fifo (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push_vld,
    input  tws_pkg::t_cmd    i_push_cmd,
    output logic             o_push_rdy,
    output logic             o_head_vld,
    output tws_pkg::t_cmd    o_head_cmd,
    input  wire              i_pop
);
    import tws_pkg::*;

    localparam int AW = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
    localparam int CW = $clog2(CMD_Q_DEPTH + 1);

    t_cmd          r_mem [CMD_Q_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          push;
    logic          pop;

    assign o_push_rdy = (r_cnt != CW'(CMD_Q_DEPTH));
    assign o_head_vld = (r_cnt != '0);
    assign o_head_cmd = r_mem[r_rd];
    assign push       = i_push_vld && o_push_rdy;
    assign pop        = i_pop && o_head_vld;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(CMD_Q_DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(CMD_Q_DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/tws_back.sv
`default_nettype none

module tws_back #(
    parameter int NUM_SLOTS    = 16,
    parameter int BUCKET_DEPTH = 64,
    parameter int SOCKET_BITS  = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cmd_vld,
    input  tws_pkg::t_cmd    i_cmd,
    output logic             o_cmd_pop,
    tws_rsp_if.source        o_rsp
);
    import tws_pkg::*;

    localparam int SLOT_W      = $clog2(NUM_SLOTS);
    localparam int FILL_W      = $clog2(BUCKET_DEPTH + 1);
    localparam int IDX_W       = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int PEND_W      = $clog2(NUM_SLOTS * BUCKET_DEPTH + 1);
    localparam int SUM_W       = $clog2(NUM_SLOTS + 16);
    localparam int SOCK_W      = (SOCKET_BITS < 16) ? SOCKET_BITS : 16;
    localparam int ADDR_W      = SLOT_W + IDX_W;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int ENTRY_W     = SOCK_W + 32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RD
    } t_state;

    function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SUM_W-1:0] s_in);
        logic [SUM_W-1:0] s;
        s = s_in;
        for (int i = 0; i < 8; i++) begin
            if (s >= SUM_W'(NUM_SLOTS)) begin
                s = s - SUM_W'(NUM_SLOTS);
            end
        end
        return s[SLOT_W-1:0];
    endfunction

    function automatic logic [6:0] ext_fill(input logic [FILL_W-1:0] v);
        logic [FILL_W+6:0] t;
        t = {7'b0, v};
        return t[6:0];
    endfunction

    function automatic logic [10:0] ext_pend(input logic [PEND_W-1:0] v);
        logic [PEND_W+10:0] t;
        t = {11'b0, v};
        return t[10:0];
    endfunction

    function automatic logic [3:0] ext_slot(input logic [SLOT_W-1:0] v);
        logic [SLOT_W+3:0] t;
        t = {4'b0, v};
        return t[3:0];
    endfunction

    function automatic logic [15:0] ext_sock(input logic [SOCK_W-1:0] v);
        logic [SOCK_W+15:0] t;
        t = {16'b0, v};
        return t[15:0];
    endfunction

    // control state
    t_state              r_state;
    logic [SLOT_W-1:0]   r_cur;
    logic [PEND_W-1:0]   r_pend;
    logic [FILL_W-1:0]   r_cur_fill;
    logic                r_out_vld;
    t_rsp                r_out;
    logic                r_mem_vld;
    logic [FILL_W-1:0]   r_rd_iss;
    logic [FILL_W-1:0]   r_emit;

    // command under way
    t_op                 r_op;
    logic [SLOT_W-1:0]   r_tgt;
    logic [SOCK_W-1:0]   r_sock;
    logic signed [31:0]  r_val;

    // fill count memory and valid bits
    logic [FILL_W-1:0]   r_fill_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_fill_vld;
    logic [FILL_W-1:0]   r_fill_q;

    // event store
    logic [ENTRY_W-1:0]  r_store_mem [STORE_DEPTH];
    logic [ENTRY_W-1:0]  r_store_q;

    logic                can_load;
    logic [SLOT_W-1:0]   slot_inc;
    logic [SLOT_W-1:0]   slot_dec;
    logic [SLOT_W-1:0]   tgt_c;
    logic                fill_re;
    logic [SLOT_W-1:0]   fill_raddr;
    logic                fill_we_c;
    logic                fill_we;
    logic [SLOT_W-1:0]   fill_waddr;
    logic [FILL_W-1:0]   fill_wdata;
    logic                store_we_c;
    logic                store_we;
    logic                store_re;
    logic                emit;
    logic                rd_last;
    logic                out_load;
    logic [SLOT_W-1:0]   n_cur;
    logic [PEND_W-1:0]   n_pend;
    logic [FILL_W-1:0]   n_cur_fill;
    logic [1:0]          status_c;

    assign can_load = !r_out_vld || o_rsp.ready;
    assign slot_inc = (r_cur == SLOT_W'(NUM_SLOTS - 1)) ? '0 : r_cur + SLOT_W'(1);
    assign slot_dec = (r_cur == '0) ? SLOT_W'(NUM_SLOTS - 1) : r_cur - SLOT_W'(1);
    assign tgt_c    = wrap_slot(SUM_W'(r_cur) + SUM_W'(i_cmd.delay));

    // front of the back end: take a command and fetch the one fill count it needs
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_vld;
    assign fill_re   = o_cmd_pop;

    always_comb begin
        unique case (i_cmd.op)
            OP_FWD:  fill_raddr = slot_inc;
            OP_BACK: fill_raddr = slot_dec;
            default: fill_raddr = tgt_c;
        endcase
    end

    // execute: next state of the wheel for the command under way
    always_comb begin
        n_cur      = r_cur;
        n_pend     = r_pend;
        n_cur_fill = r_cur_fill;
        status_c   = ST_OK;
        fill_we_c  = 1'b0;
        fill_waddr = r_tgt;
        fill_wdata = '0;
        store_we_c = 1'b0;
        unique case (r_op)
            OP_SCHED: begin
                if (r_fill_q >= FILL_W'(BUCKET_DEPTH)) begin
                    status_c = ST_OVERFLOW;
                end else begin
                    fill_we_c  = 1'b1;
                    fill_wdata = r_fill_q + FILL_W'(1);
                    store_we_c = 1'b1;
                    n_pend     = r_pend + PEND_W'(1);
                    if (r_tgt == r_cur) begin
                        n_cur_fill = r_fill_q + FILL_W'(1);
                    end
                end
            end
            OP_UNSCHED: begin
                if (r_fill_q == '0) begin
                    status_c = ST_UNDERFLOW;
                end else begin
                    fill_we_c  = 1'b1;
                    fill_wdata = r_fill_q - FILL_W'(1);
                    n_pend     = (r_pend != '0) ? r_pend - PEND_W'(1) : '0;
                    if (r_tgt == r_cur) begin
                        n_cur_fill = r_fill_q - FILL_W'(1);
                    end
                end
            end
            OP_FWD: begin
                fill_we_c  = 1'b1;
                fill_waddr = r_cur;
                fill_wdata = '0;
                n_pend     = (r_pend >= PEND_W'(r_cur_fill)) ?
                             r_pend - PEND_W'(r_cur_fill) : '0;
                n_cur      = slot_inc;
                n_cur_fill = r_fill_q;
            end
            OP_BACK: begin
                n_cur      = slot_dec;
                n_cur_fill = r_fill_q;
                if (r_fill_q != '0) begin
                    status_c = ST_BACK_NONEMPTY;
                end
            end
            default: begin
            end
        endcase
    end

    assign fill_we  = (r_state == S_EXEC) && can_load && fill_we_c;
    assign store_we = (r_state == S_EXEC) && can_load && store_we_c;

    // read walk: one store fetch ahead of the output register
    assign store_re = (r_state == S_RD) && (r_rd_iss < r_cur_fill) &&
                      (!r_mem_vld || can_load);
    assign emit     = (r_state == S_RD) && r_mem_vld && can_load;
    assign rd_last  = (r_emit == r_cur_fill - FILL_W'(1));

    // output register takes a single result or one read event
    assign out_load = ((r_state == S_EXEC) && can_load &&
                       !(r_op == OP_READ && r_cur_fill != '0)) || emit;

    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            r_fill_mem[fill_waddr] <= fill_wdata;
        end
        if (fill_re) begin
            r_fill_q <= r_fill_vld[fill_raddr] ? r_fill_mem[fill_raddr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_vld <= '0;
        end else if (fill_we) begin
            r_fill_vld[fill_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store_mem[{r_tgt, r_fill_q[IDX_W-1:0]}] <= {r_sock, r_val};
        end
        if (store_re) begin
            r_store_q <= r_store_mem[{r_cur, r_rd_iss[IDX_W-1:0]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cur      <= '0;
            r_pend     <= '0;
            r_cur_fill <= '0;
            r_out_vld  <= 1'b0;
            r_mem_vld  <= 1'b0;
            r_rd_iss   <= '0;
            r_emit     <= '0;
        end else begin
            r_out_vld <= out_load || (r_out_vld && !o_rsp.ready);
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_vld) begin
                        r_op    <= i_cmd.op;
                        r_tgt   <= tgt_c;
                        r_sock  <= i_cmd.socket_id[SOCK_W-1:0];
                        r_val   <= i_cmd.event_value;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_op == OP_READ && r_cur_fill != '0) begin
                        r_rd_iss  <= '0;
                        r_emit    <= '0;
                        r_mem_vld <= 1'b0;
                        r_state   <= S_RD;
                    end else if (can_load) begin
                        r_cur                   <= n_cur;
                        r_pend                  <= n_pend;
                        r_cur_fill              <= n_cur_fill;
                        r_out.has_event         <= 1'b0;
                        r_out.out_socket        <= '0;
                        r_out.out_value         <= '0;
                        r_out.last              <= 1'b1;
                        r_out.slot_count        <= ext_fill(n_cur_fill);
                        r_out.pending_total     <= ext_pend(n_pend);
                        r_out.now_slot          <= ext_slot(n_cur);
                        r_out.status            <= status_c;
                        r_state                 <= S_IDLE;
                    end
                end
                S_RD: begin
                    if (store_re) begin
                        r_rd_iss <= r_rd_iss + FILL_W'(1);
                    end
                    r_mem_vld <= store_re || (r_mem_vld && !emit);
                    if (emit) begin
                        r_out.has_event         <= 1'b1;
                        r_out.out_socket        <= ext_sock(r_store_q[ENTRY_W-1:32]);
                        r_out.out_value         <= r_store_q[31:0];
                        r_out.last              <= rd_last;
                        r_out.slot_count        <= ext_fill(r_cur_fill);
                        r_out.pending_total     <= ext_pend(r_pend);
                        r_out.now_slot          <= ext_slot(r_cur);
                        r_out.status            <= ST_OK;
                        r_emit                  <= r_emit + FILL_W'(1);
                        if (rd_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.has_event     = r_out.has_event;
    assign o_rsp.out_socket    = r_out.out_socket;
    assign o_rsp.out_value     = r_out.out_value;
    assign o_rsp.last          = r_out.last;
    assign o_rsp.slot_count    = r_out.slot_count;
    assign o_rsp.pending_total = r_out.pending_total;
    assign o_rsp.now_slot      = r_out.now_slot;
    assign o_rsp.status        = r_out.status;

endmodule

`default_nettype wire

// File: rtl/timing_wheel_event_scheduler.sv
// timing wheel event scheduler
// i_req carries one request per handshake: action, delay, socket_id, event_value.
// o_rsp returns results; every request gives exactly one result except a read of a
// nonempty slot, which gives one result per stored event in insertion order, the
// final one with last set.
// a front stage decodes the action and pushes a command into a two-entry queue; the
// back end takes a command, fetches the single slot count it needs from the count
// memory into a register and then executes, loading the output register.
// the back end takes no new command until the current one is done: the count
// memory read is followed by its write-back; a read of a nonempty slot sends one
// event a cycle out of the event store once the first fetch is in flight and while
// the receiver does not stall. a result is valid once the request has passed the
// front register, queue, fetch, then execute loading the output register.
// reset clears slot counts (per-slot valid bits), pointer and pending total; the
// event store needs no clearing since only written entries are ever read.
// when the receiver stalls the output register holds, the back end waits and the
// queue and front stage keep taking requests until they fill.

`default_nettype none

module timing_wheel_event_scheduler #(
    parameter int NUM_SLOTS    = 16,
    parameter int BUCKET_DEPTH = 64,
    parameter int SOCKET_BITS  = 16
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    tws_req_if.sink   i_req,
    tws_rsp_if.source o_rsp
);
    import tws_pkg::*;

    // decoded request, front register to queue
    logic front_vld;
    t_cmd front_cmd;
    logic q_push_rdy;

    // queue head to back end
    logic head_vld;
    t_cmd head_cmd;
    logic head_pop;

    tws_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_cmd_vld (front_vld),
        .o_cmd     (front_cmd),
        .i_cmd_rdy (q_push_rdy)
    );

    tws_cmd_fifo u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_vld (front_vld),
        .i_push_cmd (front_cmd),
        .o_push_rdy (q_push_rdy),
        .o_head_vld (head_vld),
        .o_head_cmd (head_cmd),
        .i_pop      (head_pop)
    );

    // back end owns the wheel: slot counts, event store, pointer, pending total
    tws_back #(
        .NUM_SLOTS    (NUM_SLOTS),
        .BUCKET_DEPTH (BUCKET_DEPTH),
        .SOCKET_BITS  (SOCKET_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (head_vld),
        .i_cmd     (head_cmd),
        .o_cmd_pop (head_pop),
        .o_rsp     (o_rsp)
    );

endmodule

`default_nettype wire
